[design/bpo_pkg.sv]
// bpo_pkg: shared types, constants and helper functions for the bezier path offset point block
// depends on nothing; imported by every module of the block
package bpo_pkg;

   localparam int GUARD_BITS = 8;
   localparam int LW         = 43;   // guard-scale value width for points and derivative terms
   localparam logic [16:0] T_ONE = 17'h10000;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_ctrl_x;
      logic signed [31:0] start_ctrl_y;
      logic signed [31:0] end_ctrl_x;
      logic signed [31:0] end_ctrl_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic [30:0]        start_width;
      logic [30:0]        end_width;
      logic [16:0]        param_t;
      logic signed [15:0] rel_offset;
   } req_type;

   typedef struct packed {
      logic signed [31:0] curve_x;
      logic signed [31:0] curve_y;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic [30:0]        width_out;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic               degenerate;
   } rsp_type;

   // values that ride alongside the normal computation
   typedef struct packed {
      logic signed [LW-1:0] f_x;
      logic signed [LW-1:0] f_y;
      logic [30:0]          wd;
      logic signed [15:0]   off;
   } side_type;

   typedef struct packed {
      logic                 valid;
      side_type             side;
      logic signed [LW-1:0] q_x;
      logic signed [LW-1:0] q_y;
   } crv_type;

   typedef struct packed {
      logic               valid;
      side_type           side;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic               deg;
   } nrm_type;

   // a + round_half_up((b - a) * t / 2^16)
   function automatic logic signed [LW-1:0] lerp(input logic signed [LW-1:0] a,
                                                 input logic signed [LW-1:0] b,
                                                 input logic [16:0] t);
      logic signed [LW:0]    diff;
      logic signed [LW+18:0] prod;
      logic signed [LW+18:0] rnd;
      diff = $signed({b[LW-1], b}) - $signed({a[LW-1], a});
      prod = diff * $signed({1'b0, t});
      rnd  = (prod + (LW+19)'(32768)) >>> 16;
      return a + $signed(rnd[LW-1:0]);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -(66'sd2147483648)) return 32'sh80000000;
      return $signed(v[31:0]);
   endfunction

endpackage

[design/bpo_curve.sv]
// bpo_curve: three-stage de casteljau for the point and the derivative, plus width interpolation
// depends on bpo_pkg
module bpo_curve
   import bpo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    in_valid,
   input  req_type in_data,
   output crv_type out
);

   typedef struct packed {
      logic signed [LW-1:0] a, b, c, e0, e1;
   } lvl1_type;

   typedef struct packed {
      logic signed [LW-1:0] ab, bc, q;
   } lvl2_type;

   function automatic lvl1_type level1(input logic signed [31:0] p0, p1, p2, p3,
                                       input logic [16:0] t);
      logic signed [LW-1:0] w0, w1, w2, w3;
      lvl1_type r;
      w0 = LW'(p0) <<< GUARD_BITS;
      w1 = LW'(p1) <<< GUARD_BITS;
      w2 = LW'(p2) <<< GUARD_BITS;
      w3 = LW'(p3) <<< GUARD_BITS;
      r.a  = lerp(w0, w1, t);
      r.b  = lerp(w1, w2, t);
      r.c  = lerp(w2, w3, t);
      r.e0 = lerp(w1 - w0, w2 - w1, t);
      r.e1 = lerp(w2 - w1, w3 - w2, t);
      return r;
   endfunction

   function automatic lvl2_type level2(input lvl1_type v, input logic [16:0] t);
      lvl2_type r;
      r.ab = lerp(v.a, v.b, t);
      r.bc = lerp(v.b, v.c, t);
      r.q  = lerp(v.e0, v.e1, t);
      return r;
   endfunction

   logic               s1_valid_ff;
   lvl1_type           s1_x_ff, s1_y_ff, s1_x_in, s1_y_in;
   logic [16:0]        s1_t_ff, s1_t_in;
   logic [47:0]        s1_pw0_ff, s1_pw1_ff, s1_pw0_in, s1_pw1_in;
   logic signed [15:0] s1_off_ff;

   logic               s2_valid_ff;
   lvl2_type           s2_x_ff, s2_y_ff, s2_x_in, s2_y_in;
   logic [16:0]        s2_t_ff;
   logic [30:0]        s2_wd_ff, s2_wd_in;
   logic signed [15:0] s2_off_ff;
   logic [47:0]        wsum;

   crv_type            out_ff, out_in;

   always_comb begin
      s1_t_in   = (in_data.param_t > T_ONE) ? T_ONE : in_data.param_t;
      s1_x_in   = level1(in_data.start_x, in_data.start_ctrl_x, in_data.end_ctrl_x,
                         in_data.end_x, s1_t_in);
      s1_y_in   = level1(in_data.start_y, in_data.start_ctrl_y, in_data.end_ctrl_y,
                         in_data.end_y, s1_t_in);
      s1_pw0_in = 48'(in_data.start_width) * 48'(T_ONE - s1_t_in);
      s1_pw1_in = 48'(in_data.end_width) * 48'(s1_t_in);
   end

   always_comb begin
      s2_x_in  = level2(s1_x_ff, s1_t_ff);
      s2_y_in  = level2(s1_y_ff, s1_t_ff);
      wsum     = s1_pw0_ff + s1_pw1_ff + 48'd32768;
      s2_wd_in = wsum[46:16];
   end

   always_comb begin
      out_in.valid    = s2_valid_ff;
      out_in.side.f_x = lerp(s2_x_ff.ab, s2_x_ff.bc, s2_t_ff);
      out_in.side.f_y = lerp(s2_y_ff.ab, s2_y_ff.bc, s2_t_ff);
      out_in.side.wd  = s2_wd_ff;
      out_in.side.off = s2_off_ff;
      out_in.q_x      = s2_x_ff.q;
      out_in.q_y      = s2_y_ff.q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s1_x_ff     <= s1_x_in;
         s1_y_ff     <= s1_y_in;
         s1_t_ff     <= s1_t_in;
         s1_pw0_ff   <= s1_pw0_in;
         s1_pw1_ff   <= s1_pw1_in;
         s1_off_ff   <= in_data.rel_offset;
         s2_x_ff     <= s2_x_in;
         s2_y_ff     <= s2_y_in;
         s2_t_ff     <= s1_t_ff;
         s2_wd_ff    <= s2_wd_in;
         s2_off_ff   <= s1_off_ff;
         out_ff      <= out_in;
      end
   end

   assign out = out_ff;

endmodule

[design/bpo_norm.sv]
// bpo_norm: pipelined unit normal: magnitude normalize, square root one bit a stage,
// two restoring dividers one quotient bit a stage; depends on bpo_pkg
module bpo_norm
   import bpo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  crv_type in,
   output nrm_type out
);

   localparam int ROOT_STEPS = 31;
   localparam int DIV_STEPS  = 15;
   localparam int ST_MSB     = 2;
   localparam int ST_SHIFT   = 3;
   localparam int ST_SQ      = 4;
   localparam int ST_SUM     = 5;
   localparam int ST_ROOT0   = 6;
   localparam int ST_DIVPREP = ST_ROOT0 + ROOT_STEPS;
   localparam int ST_DIV0    = ST_DIVPREP + 1;
   localparam int ST_SIGN    = ST_DIV0 + DIV_STEPS;

   typedef struct packed {
      logic               valid;
      side_type           side;
      logic               neg_x;
      logic               pos_y;
      logic               deg;
      logic [40:0]        mag_x, mag_y;
      logic [5:0]         msb;
      logic [59:0]        sq_x, sq_y;
      logic [61:0]        rem, root;
      logic [44:0]        num_x, num_y;
      logic [14:0]        quo_x, quo_y;
      logic signed [15:0] nx, ny;
   } nrec_type;

   function automatic nrec_type step_abs(input crv_type c);
      nrec_type r;
      logic signed [LW-1:0] ax, ay;
      r       = '0;
      r.valid = c.valid;
      r.side  = c.side;
      r.neg_x = c.q_x < 0;
      r.pos_y = c.q_y > 0;
      r.deg   = (c.q_x == '0) && (c.q_y == '0);
      ax      = c.q_x < 0 ? -c.q_x : c.q_x;
      ay      = c.q_y < 0 ? -c.q_y : c.q_y;
      r.mag_x = ax[40:0];
      r.mag_y = ay[40:0];
      return r;
   endfunction

   function automatic nrec_type step_msb(input nrec_type v);
      nrec_type r;
      logic [40:0] m;
      r = v;
      m = (v.mag_x > v.mag_y) ? v.mag_x : v.mag_y;
      r.msb = '0;
      for (int i = 0; i < 41; i++) begin
         if (m[i]) r.msb = 6'(i);
      end
      return r;
   endfunction

   // bring the larger magnitude into [2^29, 2^30)
   function automatic nrec_type step_shift(input nrec_type v);
      nrec_type r;
      r = v;
      if (v.msb > 6'd29) begin
         r.mag_x = v.mag_x >> (v.msb - 6'd29);
         r.mag_y = v.mag_y >> (v.msb - 6'd29);
      end else begin
         r.mag_x = v.mag_x << (6'd29 - v.msb);
         r.mag_y = v.mag_y << (6'd29 - v.msb);
      end
      return r;
   endfunction

   function automatic nrec_type step_sq(input nrec_type v);
      nrec_type r;
      r = v;
      r.sq_x = 60'(v.mag_x[29:0]) * 60'(v.mag_x[29:0]);
      r.sq_y = 60'(v.mag_y[29:0]) * 60'(v.mag_y[29:0]);
      return r;
   endfunction

   function automatic nrec_type step_sum(input nrec_type v);
      nrec_type r;
      r = v;
      r.rem  = 62'(v.sq_x) + 62'(v.sq_y);
      r.root = '0;
      return r;
   endfunction

   function automatic nrec_type step_root(input nrec_type v, input int idx);
      nrec_type r;
      logic [61:0] bitv;
      r = v;
      bitv = 62'(1) << (60 - 2 * idx);
      if (v.rem >= v.root + bitv) begin
         r.rem  = v.rem - (v.root + bitv);
         r.root = (v.root >> 1) + bitv;
      end else begin
         r.root = v.root >> 1;
      end
      return r;
   endfunction

   function automatic nrec_type step_divprep(input nrec_type v);
      nrec_type r;
      r = v;
      r.num_x = (45'(v.mag_x[29:0]) << 14) + 45'(v.root[30:1]);
      r.num_y = (45'(v.mag_y[29:0]) << 14) + 45'(v.root[30:1]);
      r.quo_x = '0;
      r.quo_y = '0;
      return r;
   endfunction

   function automatic nrec_type step_div(input nrec_type v, input int bi);
      nrec_type r;
      logic [44:0] d;
      r = v;
      d = 45'(v.root[30:0]) << bi;
      if (v.num_x >= d) begin
         r.num_x     = v.num_x - d;
         r.quo_x[bi] = 1'b1;
      end
      if (v.num_y >= d) begin
         r.num_y     = v.num_y - d;
         r.quo_y[bi] = 1'b1;
      end
      return r;
   endfunction

   // turn by +90 degrees; zero derivative forces a zero normal
   function automatic nrec_type step_sign(input nrec_type v);
      nrec_type r;
      logic signed [15:0] cx, cy;
      r  = v;
      cx = $signed({1'b0, v.quo_x});
      cy = $signed({1'b0, v.quo_y});
      r.nx = v.deg ? 16'sd0 : (v.pos_y ? -cy : cy);
      r.ny = v.deg ? 16'sd0 : (v.neg_x ? -cx : cx);
      return r;
   endfunction

   nrec_type rec_ff [1:ST_SIGN];
   nrec_type rec_in [1:ST_SIGN];

   assign rec_in[1] = step_abs(in);

   for (genvar k = 2; k <= ST_SIGN; k++) begin : g_stage
      if (k == ST_MSB) begin : g_msb
         assign rec_in[k] = step_msb(rec_ff[k-1]);
      end else if (k == ST_SHIFT) begin : g_shift
         assign rec_in[k] = step_shift(rec_ff[k-1]);
      end else if (k == ST_SQ) begin : g_sq
         assign rec_in[k] = step_sq(rec_ff[k-1]);
      end else if (k == ST_SUM) begin : g_sum
         assign rec_in[k] = step_sum(rec_ff[k-1]);
      end else if (k < ST_DIVPREP) begin : g_root
         assign rec_in[k] = step_root(rec_ff[k-1], k - ST_ROOT0);
      end else if (k == ST_DIVPREP) begin : g_prep
         assign rec_in[k] = step_divprep(rec_ff[k-1]);
      end else if (k < ST_SIGN) begin : g_div
         assign rec_in[k] = step_div(rec_ff[k-1], DIV_STEPS - 1 - (k - ST_DIV0));
      end else begin : g_sign
         assign rec_in[k] = step_sign(rec_ff[k-1]);
      end
   end

   for (genvar k = 1; k <= ST_SIGN; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            rec_ff[k].valid <= 1'b0;
         end else if (adv) begin
            rec_ff[k] <= rec_in[k];
         end
      end
   end

   assign out.valid = rec_ff[ST_SIGN].valid;
   assign out.side  = rec_ff[ST_SIGN].side;
   assign out.nx    = rec_ff[ST_SIGN].nx;
   assign out.ny    = rec_ff[ST_SIGN].ny;
   assign out.deg   = rec_ff[ST_SIGN].deg;

endmodule

[design/bpo_offset.sv]
// bpo_offset: offset point from normal, width and relative offset; rounding and saturation
// three stages, the last is the result register; depends on bpo_pkg
module bpo_offset
   import bpo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  nrm_type in,
   output logic    out_valid,
   output rsp_type out_data
);

   logic               o1_valid_ff;
   nrm_type            o1_n_ff;
   logic signed [47:0] o1_px_ff, o1_py_ff, o1_px_in, o1_py_in;

   logic               o2_valid_ff;
   nrm_type            o2_n_ff;
   logic signed [63:0] o2_px_ff, o2_py_ff, o2_px_in, o2_py_in;

   logic               out_valid_ff;
   rsp_type            out_ff, out_in;

   always_comb begin
      o1_px_in = in.nx * $signed({1'b0, in.side.wd});
      o1_py_in = in.ny * $signed({1'b0, in.side.wd});
      o2_px_in = o1_px_ff * o1_n_ff.side.off;
      o2_py_in = o1_py_ff * o1_n_ff.side.off;
   end

   always_comb begin
      out_in.curve_x    = sat32((66'(o2_n_ff.side.f_x) + 66'sd128) >>> GUARD_BITS);
      out_in.curve_y    = sat32((66'(o2_n_ff.side.f_y) + 66'sd128) >>> GUARD_BITS);
      out_in.normal_x   = o2_n_ff.nx;
      out_in.normal_y   = o2_n_ff.ny;
      out_in.width_out  = o2_n_ff.side.wd;
      out_in.offset_x   = sat32(((66'(o2_n_ff.side.f_x) <<< 19) + 66'(o2_px_ff)
                                 + (66'sd1 <<< 26)) >>> 27);
      out_in.offset_y   = sat32(((66'(o2_n_ff.side.f_y) <<< 19) + 66'(o2_py_ff)
                                 + (66'sd1 <<< 26)) >>> 27);
      out_in.degenerate = o2_n_ff.deg;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o1_n_ff  <= in;
         o1_px_ff <= o1_px_in;
         o1_py_ff <= o1_py_in;
         o2_n_ff  <= o1_n_ff;
         o2_px_ff <= o2_px_in;
         o2_py_ff <= o2_py_in;
         out_ff   <= out_in;
      end
      if (reset) begin
         o1_valid_ff  <= 1'b0;
         o2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         o1_valid_ff  <= in.valid;
         o2_valid_ff  <= o1_valid_ff;
         out_valid_ff <= o2_valid_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

[design/bezier_path_offset_point.sv]
// bezier_path_offset_point: an accepted transaction passes the de casteljau stages, the normal
// unit (square root, then divide) and the offset stages; throughput one transaction per cycle
// while no result is stalled; the square root and divider run one bit per stage.
// a stalled result freezes the whole pipeline in place, nothing is dropped or repeated.
// reset (synchronous, active high) clears the valid bits only; no clearing pass.
module bezier_path_offset_point
   import bpo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // pipeline advance: every stage moves unless a held result waits downstream
   logic    adv;
   crv_type crv;
   nrm_type nrm;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // point, derivative and width
   bpo_curve u_curve (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_data  (req_payload),
      .out      (crv)
   );

   // unit normal with its side payload delayed alongside
   bpo_norm u_norm (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (crv),
      .out   (nrm)
   );

   // offset point, rounding, saturation and result register
   bpo_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in        (nrm),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload)
   );

   // input is only held back while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled without a waiting result");

   // zero derivative gives a zero normal
   a_deg_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.degenerate |->
         rsp_payload.normal_x == 16'sd0 && rsp_payload.normal_y == 16'sd0)
      else $error("degenerate result with nonzero normal");

   // with a zero normal the offset point is the curve point
   a_deg_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.degenerate |->
         rsp_payload.offset_x == rsp_payload.curve_x &&
         rsp_payload.offset_y == rsp_payload.curve_y)
      else $error("degenerate offset differs from curve point");

   // normal components stay within one in q1.14
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_payload.normal_x >= -16'sd16384 && rsp_payload.normal_x <= 16'sd16384 &&
         rsp_payload.normal_y >= -16'sd16384 && rsp_payload.normal_y <= 16'sd16384)
      else $error("normal component out of range");

endmodule
